// ===== design/alfl_pkg.sv =====
package alfl_pkg;

    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Program addresses of the sequencer.
    typedef enum logic [4:0] {
        S_CLR   = 5'd0,
        S_IDLE  = 5'd1,
        S_DISP  = 5'd2,
        S_I0    = 5'd3,
        S_FULL  = 5'd4,
        S_I1    = 5'd5,
        S_I2    = 5'd6,
        S_I3    = 5'd7,
        S_I4    = 5'd8,
        S_D0    = 5'd9,
        S_EMPTY = 5'd10,
        S_D1    = 5'd11,
        S_RANGE = 5'd12,
        S_D2    = 5'd13,
        S_DH    = 5'd14,
        S_DW    = 5'd15,
        S_DV    = 5'd16,
        S_DU    = 5'd17,
        S_DF    = 5'd18,
        S_DONE  = 5'd19
    } t_step;

    typedef enum logic [3:0] {
        C_ALWAYS   = 4'd0,
        C_ACCEPT   = 4'd1,
        C_OP       = 4'd2,
        C_FREE_NIL = 4'd3,
        C_HEAD_NIL = 4'd4,
        C_LRD_NIL  = 4'd5,
        C_EMPTY    = 4'd6,
        C_BADPOS   = 4'd7,
        C_POS1     = 4'd8,
        C_CNT_LT   = 4'd9,
        C_OUT_FREE = 4'd10,
        C_CLR_LAST = 4'd11
    } t_cond;

    typedef enum logic [4:0] {
        A_NOP   = 5'd0,
        A_CLR   = 5'd1,
        A_LOAD  = 5'd2,
        A_I0    = 5'd3,
        A_FULL  = 5'd4,
        A_I1    = 5'd5,
        A_HEADN = 5'd6,
        A_WALK  = 5'd7,
        A_LINKT = 5'd8,
        A_EMPTY = 5'd9,
        A_D1    = 5'd10,
        A_RANGE = 5'd11,
        A_DH    = 5'd12,
        A_DWALK = 5'd13,
        A_DV    = 5'd14,
        A_DU    = 5'd15,
        A_DF    = 5'd16,
        A_EMIT  = 5'd17
    } t_act;

    // One control word: the condition picks both the next step and the action.
    typedef struct packed {
        logic  ready;
        t_cond cond;
        t_step next_t;
        t_step next_f;
        t_act  act_t;
        t_act  act_f;
    } t_cw;

    function automatic t_cw mk_cw(logic rdy, t_cond c, t_step nt, t_step nf, t_act at, t_act af);
        t_cw w;
        w.ready  = rdy;
        w.cond   = c;
        w.next_t = nt;
        w.next_f = nf;
        w.act_t  = at;
        w.act_f  = af;
        return w;
    endfunction

    function automatic t_cw ucode(t_step s);
        t_cw w;
        unique case (s)
            S_CLR:   w = mk_cw(1'b0, C_CLR_LAST, S_IDLE,  S_CLR,   A_CLR,   A_CLR);
            S_IDLE:  w = mk_cw(1'b1, C_ACCEPT,   S_DISP,  S_IDLE,  A_LOAD,  A_NOP);
            S_DISP:  w = mk_cw(1'b0, C_OP,       S_D0,    S_I0,    A_NOP,   A_NOP);
            S_I0:    w = mk_cw(1'b0, C_FREE_NIL, S_FULL,  S_I1,    A_NOP,   A_I0);
            S_FULL:  w = mk_cw(1'b0, C_ALWAYS,   S_DONE,  S_DONE,  A_FULL,  A_FULL);
            S_I1:    w = mk_cw(1'b0, C_HEAD_NIL, S_I4,    S_I2,    A_I1,    A_I1);
            S_I2:    w = mk_cw(1'b0, C_LRD_NIL,  S_I3,    S_I2,    A_NOP,   A_WALK);
            S_I3:    w = mk_cw(1'b0, C_ALWAYS,   S_DONE,  S_DONE,  A_LINKT, A_LINKT);
            S_I4:    w = mk_cw(1'b0, C_ALWAYS,   S_DONE,  S_DONE,  A_HEADN, A_HEADN);
            S_D0:    w = mk_cw(1'b0, C_EMPTY,    S_EMPTY, S_D1,    A_NOP,   A_NOP);
            S_EMPTY: w = mk_cw(1'b0, C_ALWAYS,   S_DONE,  S_DONE,  A_EMPTY, A_EMPTY);
            S_D1:    w = mk_cw(1'b0, C_BADPOS,   S_RANGE, S_D2,    A_NOP,   A_D1);
            S_RANGE: w = mk_cw(1'b0, C_ALWAYS,   S_DONE,  S_DONE,  A_RANGE, A_RANGE);
            S_D2:    w = mk_cw(1'b0, C_POS1,     S_DH,    S_DW,    A_NOP,   A_NOP);
            S_DH:    w = mk_cw(1'b0, C_ALWAYS,   S_DF,    S_DF,    A_DH,    A_DH);
            S_DW:    w = mk_cw(1'b0, C_CNT_LT,   S_DW,    S_DV,    A_DWALK, A_NOP);
            S_DV:    w = mk_cw(1'b0, C_LRD_NIL,  S_RANGE, S_DU,    A_NOP,   A_DV);
            S_DU:    w = mk_cw(1'b0, C_ALWAYS,   S_DF,    S_DF,    A_DU,    A_DU);
            S_DF:    w = mk_cw(1'b0, C_ALWAYS,   S_DONE,  S_DONE,  A_DF,    A_DF);
            S_DONE:  w = mk_cw(1'b0, C_OUT_FREE, S_IDLE,  S_DONE,  A_EMIT,  A_NOP);
            default: w = mk_cw(1'b0, C_ALWAYS,   S_IDLE,  S_IDLE,  A_NOP,   A_NOP);
        endcase
        return w;
    endfunction

endpackage

// ===== design/alfl_if.sv =====
interface alfl_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic signed [alfl_pkg::VALUE_W-1:0] value;
    logic [alfl_pkg::POS_W-1:0]          position;

    modport source (output valid, output op, output value, output position, input ready);
    modport sink   (input valid, input op, input value, input position, output ready);
endinterface

interface alfl_out_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [alfl_pkg::VALUE_W-1:0] removed_value;

    modport source (output valid, output status, output removed_value, input ready);
    modport sink   (input valid, input status, input removed_value, output ready);
endinterface

// ===== design/array_linked_list_with_free_list.sv =====
// Operation: an insert walks the list from the head to the tail and links the new node there,
// a delete walks to the node before position p (none for position 1) and unlinks the victim,
// and a rejected request ends without a walk; one node link is read per cycle while walking.
// Throughput: one transaction at a time.
// Reset: synchronous, active low; a clearing pass then rebuilds the free list,
// during which no transaction is accepted. Node values are not cleared.
module array_linked_list_with_free_list #(
    parameter int NODES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    alfl_in_if.sink           i_in,
    alfl_out_if.source        o_out
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int IW = $clog2(NODES + 1);
    localparam int CW = (IW > alfl_pkg::POS_W) ? IW : alfl_pkg::POS_W;
    localparam logic [IW-1:0] NIL = IW'(NODES);

    // Node stores.
    logic [IW-1:0]                       r_link [NODES];
    logic signed [alfl_pkg::VALUE_W-1:0] r_val  [NODES];
    logic [IW-1:0]                       r_lrd;
    logic signed [alfl_pkg::VALUE_W-1:0] r_vrd;

    // Sequencer and datapath registers.
    alfl_pkg::t_step                     r_step, n_step;
    logic [IW-1:0]                       r_head, n_head;
    logic [IW-1:0]                       r_free, n_free;
    logic [IW-1:0]                       r_len, n_len;
    logic [IW-1:0]                       r_ptr, n_ptr;
    logic [IW-1:0]                       r_node, n_node;
    logic [alfl_pkg::POS_W-1:0]          r_cnt, n_cnt;
    logic                                r_op, n_op;
    logic signed [alfl_pkg::VALUE_W-1:0] r_data, n_data;
    logic [alfl_pkg::POS_W-1:0]          r_pos, n_pos;
    alfl_pkg::t_status                   r_status, n_status;
    logic signed [alfl_pkg::VALUE_W-1:0] r_removed, n_removed;
    logic                                r_out_valid, n_out_valid;
    alfl_pkg::t_status                   r_out_status, n_out_status;
    logic signed [alfl_pkg::VALUE_W-1:0] r_out_removed, n_out_removed;

    alfl_pkg::t_cw                       cw;
    alfl_pkg::t_act                      act;
    logic                                cond_true;
    logic                                link_we, link_re, val_we, val_re;
    logic [AW-1:0]                       link_wa, link_ra, val_wa, val_ra;
    logic [IW-1:0]                       link_wd;

    assign cw         = alfl_pkg::ucode(r_step);
    assign i_in.ready = cw.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.removed_value = r_out_removed;

    always_comb begin
        unique case (cw.cond)
            alfl_pkg::C_ALWAYS:   cond_true = 1'b1;
            alfl_pkg::C_ACCEPT:   cond_true = i_in.valid;
            alfl_pkg::C_OP:       cond_true = r_op;
            alfl_pkg::C_FREE_NIL: cond_true = (r_free == NIL);
            alfl_pkg::C_HEAD_NIL: cond_true = (r_head == NIL);
            alfl_pkg::C_LRD_NIL:  cond_true = (r_lrd == NIL);
            alfl_pkg::C_EMPTY:    cond_true = (r_head == NIL) || (r_len == '0);
            alfl_pkg::C_BADPOS:   cond_true = (r_pos == '0) || (CW'(r_pos) > CW'(r_len));
            alfl_pkg::C_POS1:     cond_true = (r_pos == alfl_pkg::POS_W'(1));
            alfl_pkg::C_CNT_LT:   cond_true = (r_cnt < r_pos);
            alfl_pkg::C_OUT_FREE: cond_true = !r_out_valid || o_out.ready;
            alfl_pkg::C_CLR_LAST: cond_true = (r_ptr == IW'(NODES - 1));
            default:              cond_true = 1'b1;
        endcase
    end

    assign n_step = cond_true ? cw.next_t : cw.next_f;
    assign act    = cond_true ? cw.act_t  : cw.act_f;

    always_comb begin
        n_head        = r_head;
        n_free        = r_free;
        n_len         = r_len;
        n_ptr         = r_ptr;
        n_node        = r_node;
        n_cnt         = r_cnt;
        n_op          = r_op;
        n_data        = r_data;
        n_pos         = r_pos;
        n_status      = r_status;
        n_removed     = r_removed;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_status  = r_out_status;
        n_out_removed = r_out_removed;
        link_we       = 1'b0;
        link_wa       = r_ptr[AW-1:0];
        link_wd       = r_node;
        link_re       = 1'b0;
        link_ra       = r_lrd[AW-1:0];
        val_we        = 1'b0;
        val_wa        = r_node[AW-1:0];
        val_re        = 1'b0;
        val_ra        = r_lrd[AW-1:0];

        unique case (act)
            alfl_pkg::A_NOP: begin
            end
            alfl_pkg::A_CLR: begin
                link_we = 1'b1;
                link_wd = IW'(r_ptr + 1'b1);
                n_ptr   = IW'(r_ptr + 1'b1);
            end
            alfl_pkg::A_LOAD: begin
                n_op      = i_in.op;
                n_data    = i_in.value;
                n_pos     = i_in.position;
                n_removed = '0;
            end
            alfl_pkg::A_I0: begin
                n_node  = r_free;
                link_re = 1'b1;
                link_ra = r_free[AW-1:0];
            end
            alfl_pkg::A_FULL: begin
                n_status = alfl_pkg::ST_FULL;
            end
            alfl_pkg::A_I1: begin
                n_free  = r_lrd;
                val_we  = 1'b1;
                link_we = 1'b1;
                link_wa = r_node[AW-1:0];
                link_wd = NIL;
                n_ptr   = r_head;
                link_re = 1'b1;
                link_ra = r_head[AW-1:0];
            end
            alfl_pkg::A_HEADN: begin
                n_head   = r_node;
                n_len    = IW'(r_len + 1'b1);
                n_status = alfl_pkg::ST_OK;
            end
            alfl_pkg::A_WALK: begin
                n_ptr   = r_lrd;
                link_re = 1'b1;
            end
            alfl_pkg::A_LINKT: begin
                link_we  = 1'b1;
                n_len    = IW'(r_len + 1'b1);
                n_status = alfl_pkg::ST_OK;
            end
            alfl_pkg::A_EMPTY: begin
                n_status = alfl_pkg::ST_EMPTY;
            end
            alfl_pkg::A_D1: begin
                n_ptr   = r_head;
                n_node  = r_head;
                n_cnt   = alfl_pkg::POS_W'(2);
                link_re = 1'b1;
                link_ra = r_head[AW-1:0];
                val_re  = 1'b1;
                val_ra  = r_head[AW-1:0];
            end
            alfl_pkg::A_RANGE: begin
                n_status = alfl_pkg::ST_RANGE;
            end
            alfl_pkg::A_DH: begin
                n_head = r_lrd;
            end
            alfl_pkg::A_DWALK: begin
                n_ptr   = r_lrd;
                n_cnt   = alfl_pkg::POS_W'(r_cnt + 1'b1);
                link_re = 1'b1;
            end
            alfl_pkg::A_DV: begin
                n_node  = r_lrd;
                link_re = 1'b1;
                val_re  = 1'b1;
            end
            alfl_pkg::A_DU: begin
                // The predecessor now skips the victim.
                link_we = 1'b1;
                link_wd = r_lrd;
            end
            alfl_pkg::A_DF: begin
                n_removed = r_vrd;
                link_we   = 1'b1;
                link_wa   = r_node[AW-1:0];
                link_wd   = r_free;
                n_free    = r_node;
                n_len     = IW'(r_len - 1'b1);
                n_status  = alfl_pkg::ST_OK;
            end
            alfl_pkg::A_EMIT: begin
                n_out_valid   = 1'b1;
                n_out_status  = r_status;
                n_out_removed = r_removed;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link[link_wa] <= link_wd;
        end
        if (link_re) begin
            r_lrd <= r_link[link_ra];
        end
        if (val_we) begin
            r_val[val_wa] <= r_data;
        end
        if (val_re) begin
            r_vrd <= r_val[val_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= alfl_pkg::S_CLR;
            r_head      <= NIL;
            r_free      <= '0;
            r_len       <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_head      <= n_head;
            r_free      <= n_free;
            r_len       <= n_len;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node        <= n_node;
        r_cnt         <= n_cnt;
        r_op          <= n_op;
        r_data        <= n_data;
        r_pos         <= n_pos;
        r_status      <= n_status;
        r_removed     <= n_removed;
        r_out_status  <= n_out_status;
        r_out_removed <= n_out_removed;
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= IW'(NODES))
        else $error("list length exceeds the node count");

    a_free_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == alfl_pkg::S_IDLE && r_free == NIL) |-> (r_len == IW'(NODES)))
        else $error("free list empty while the list is not full");

    a_head_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == alfl_pkg::S_IDLE) |-> ((r_head == NIL) == (r_len == '0)))
        else $error("list head and length disagree");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_step) == alfl_pkg::S_DONE))
        else $error("result raised outside the final step");

    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != alfl_pkg::ST_OK) |-> (r_out_removed == '0))
        else $error("removed value set on a failed transaction");

endmodule
